@@ rtl/mbp_pkg.sv @@
// mbp_pkg: shared widths and item types for the mipmap box filter pyramid core.
// No dependencies; every other file of the block refers to it by scoped names.
package mbp_pkg;

   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 3 * CHAN_W;
   localparam int PAIR_W  = 9;
   localparam int SUMS_W  = 3 * PAIR_W;
   localparam int LEVEL_W = 3;
   localparam int POS_W   = 9;
   localparam int CFG_W   = 11;

   // texel handed from one filter cell to the next
   typedef struct packed {
      logic              valid;
      logic [PIX_W-1:0]  pix;
   } tok_type;

   // one result item
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [POS_W-1:0]   row;
      logic [POS_W-1:0]   column;
      logic [CHAN_W-1:0]  out_red;
      logic [CHAN_W-1:0]  out_green;
      logic [CHAN_W-1:0]  out_blue;
      logic               last_in_run;
   } rsp_item_type;

   // result item offered by a cell in the cycle it finishes a texel
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } res_type;

endpackage

@@ rtl/mbp_req_if.sv @@
// mbp_req_if: valid/ready channel carrying one base pixel item.
// Depends on mbp_pkg for channel widths.
interface mbp_req_if;
   logic                      valid;
   logic                      ready;
   logic [mbp_pkg::CHAN_W-1:0] red;
   logic [mbp_pkg::CHAN_W-1:0] green;
   logic [mbp_pkg::CHAN_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ rtl/mbp_rsp_if.sv @@
// mbp_rsp_if: valid/ready channel carrying one finished texel item.
// Depends on mbp_pkg for field widths.
interface mbp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mbp_pkg::LEVEL_W-1:0] level;
   logic [mbp_pkg::POS_W-1:0]   row;
   logic [mbp_pkg::POS_W-1:0]   column;
   logic [mbp_pkg::CHAN_W-1:0]  out_red;
   logic [mbp_pkg::CHAN_W-1:0]  out_green;
   logic [mbp_pkg::CHAN_W-1:0]  out_blue;
   logic                        last_in_run;

   modport source (output valid, output level, output row, output column, output out_red,
                   output out_green, output out_blue, output last_in_run, input ready);
   modport sink   (input valid, input level, input row, input column, input out_red,
                   input out_green, input out_blue, input last_in_run, output ready);
endinterface

@@ rtl/mbp_cell.sv @@
// mbp_cell: one 2x2 box filter stage of the pyramid, with its own counters,
// left pixel register and line buffer of top pair sums. Depends on mbp_pkg.
module mbp_cell #(
   parameter int STAGE    = 0,
   parameter int MAX_SIDE = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic [$clog2(MAX_SIDE+1)-1:0] side,
   input  mbp_pkg::tok_type        up_tok,
   input  logic                    next_make,
   output mbp_pkg::tok_type        dn_tok,
   output logic                    make,
   output mbp_pkg::res_type        res
);

   localparam int CW    = $clog2(MAX_SIDE);
   localparam int SW    = $clog2(MAX_SIDE + 1);
   localparam int XW    = CW + 9;
   localparam int SPAN  = MAX_SIDE >> STAGE;
   localparam int HALF  = (SPAN + 1) >> 1;
   localparam int DEPTH = (HALF > 0) ? HALF : 1;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [mbp_pkg::LEVEL_W-1:0] LVL = mbp_pkg::LEVEL_W'((STAGE + 1) % 8);

   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;
   logic [mbp_pkg::PIX_W-1:0]  left_ff;
   logic [mbp_pkg::SUMS_W-1:0] mem [DEPTH];
   logic [mbp_pkg::SUMS_W-1:0] rd_ff;
   mbp_pkg::tok_type           dn_tok_ff, dn_tok_in;

   logic [SW-1:0] s_raw, s_eff, n2, col_x, row_x, col_p1, row_p1;
   logic          in_blk, fire;
   logic [mbp_pkg::SUMS_W-1:0] pair;
   logic [mbp_pkg::PIX_W-1:0]  avg;
   logic [9:0]    sum4 [3];
   logic [CW-1:0] wr_half, rd_half;
   logic [XW-1:0] row_w, col_w;

   // level geometry and texel position test
   always_comb begin
      s_raw  = side >> STAGE;
      s_eff  = (s_raw == '0) ? SW'(1) : s_raw;
      n2     = {s_eff[SW-1:1], 1'b0};
      col_x  = SW'(col_ff);
      row_x  = SW'(row_ff);
      col_p1 = col_x + SW'(1);
      row_p1 = row_x + SW'(1);
      in_blk = (col_x < n2) && (row_x < n2);
      make   = in_blk && col_ff[0] && row_ff[0];
      fire   = adv && up_tok.valid;
   end

   // counter advance with wrap at the end of row and frame
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (fire) begin
         if (col_p1 >= s_eff) begin
            col_in = '0;
            row_in = (row_p1 >= s_eff) ? '0 : CW'(row_p1);
         end else begin
            col_in = CW'(col_p1);
         end
      end
   end

   // horizontal pair sums and 2x2 means per channel
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         pair[c*mbp_pkg::PAIR_W +: mbp_pkg::PAIR_W] =
            mbp_pkg::PAIR_W'(left_ff[c*mbp_pkg::CHAN_W +: mbp_pkg::CHAN_W]) +
            mbp_pkg::PAIR_W'(up_tok.pix[c*mbp_pkg::CHAN_W +: mbp_pkg::CHAN_W]);
         sum4[c] = 10'(rd_ff[c*mbp_pkg::PAIR_W +: mbp_pkg::PAIR_W]) +
                   10'(pair[c*mbp_pkg::PAIR_W +: mbp_pkg::PAIR_W]);
         avg[c*mbp_pkg::CHAN_W +: mbp_pkg::CHAN_W] = sum4[c][9:2];
      end
   end

   // line buffer addresses: write at the current column, prefetch at the next one
   always_comb begin
      wr_half = col_ff >> 1;
      rd_half = col_in >> 1;
      row_w   = XW'(row_ff >> 1);
      col_w   = XW'(col_ff >> 1);
   end

   // result item and texel for the next cell
   always_comb begin
      res.valid            = fire && make;
      res.item.level       = LVL;
      res.item.row         = row_w[mbp_pkg::POS_W-1:0];
      res.item.column      = col_w[mbp_pkg::POS_W-1:0];
      res.item.out_red     = avg[0*mbp_pkg::CHAN_W +: mbp_pkg::CHAN_W];
      res.item.out_green   = avg[1*mbp_pkg::CHAN_W +: mbp_pkg::CHAN_W];
      res.item.out_blue    = avg[2*mbp_pkg::CHAN_W +: mbp_pkg::CHAN_W];
      res.item.last_in_run = !next_make;
      dn_tok_in = dn_tok_ff;
      if (adv) begin
         dn_tok_in.valid = fire && make;
         dn_tok_in.pix   = avg;
      end
   end

   assign dn_tok = dn_tok_ff;

   // counters and handoff register
   always_ff @(posedge clock) begin
      dn_tok_ff.pix <= dn_tok_in.pix;
      if (reset) begin
         col_ff          <= '0;
         row_ff          <= '0;
         dn_tok_ff.valid <= 1'b0;
      end else begin
         col_ff          <= col_in;
         row_ff          <= row_in;
         dn_tok_ff.valid <= dn_tok_in.valid;
      end
   end

   // payload: left pixel, line buffer and its registered read
   always_ff @(posedge clock) begin
      if (fire && in_blk && !col_ff[0]) begin
         left_ff <= up_tok.pix;
      end
      if (fire && in_blk && col_ff[0] && !row_ff[0]) begin
         mem[wr_half[AW-1:0]] <= pair;
      end
      rd_ff <= mem[rd_half[AW-1:0]];
   end

endmodule

@@ rtl/mbp_out_queue.sv @@
// mbp_out_queue: two-entry result queue that drives the rsp channel from registers.
// Depends on mbp_pkg and mbp_rsp_if.
module mbp_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mbp_pkg::rsp_item_type push_item,
   output logic                 space,
   mbp_rsp_if.source            rsp_item
);

   mbp_pkg::rsp_item_type slot0_ff, slot0_in;
   mbp_pkg::rsp_item_type slot1_ff, slot1_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic                  pop;

   assign pop   = (cnt_ff != 2'd0) && rsp_item.ready;
   assign space = (cnt_ff != 2'd2);

   // queue update
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff;
      case ({push, pop})
         2'b10: begin
            if (cnt_ff == 2'd0) slot0_in = push_item;
            else                slot1_in = push_item;
            cnt_in = cnt_ff + 2'd1;
         end
         2'b01: begin
            slot0_in = slot1_ff;
            cnt_in   = cnt_ff - 2'd1;
         end
         2'b11: begin
            if (cnt_ff == 2'd1) begin
               slot0_in = push_item;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = push_item;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // head entry drives the channel
   assign rsp_item.valid       = (cnt_ff != 2'd0);
   assign rsp_item.level       = slot0_ff.level;
   assign rsp_item.row         = slot0_ff.row;
   assign rsp_item.column      = slot0_ff.column;
   assign rsp_item.out_red     = slot0_ff.out_red;
   assign rsp_item.out_green   = slot0_ff.out_green;
   assign rsp_item.out_blue    = slot0_ff.out_blue;
   assign rsp_item.last_in_run = slot0_ff.last_in_run;

endmodule

@@ rtl/mipmap_box_filter_pyramid_core.sv @@
// mipmap_box_filter_pyramid_core: chain of LEVELS-1 box filter cells, one per level.
// Throughput: one pixel item per cycle while the result queue has space; a pixel that
// finishes a level-1 texel waits while an earlier cascade still runs in deeper cells.
// A level-l texel passes each earlier cell's handoff register, then the result queue.
// Reset clears counters, sets side_ff to min(256, MAX_SIDE); line buffers stay as is.
// Depends on mbp_pkg, mbp_req_if, mbp_rsp_if, mbp_cell and mbp_out_queue.
module mipmap_box_filter_pyramid_core #(
   parameter int LEVELS   = 8,
   parameter int MAX_SIDE = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [mbp_pkg::CFG_W-1:0]  csr_wdata,
   mbp_req_if.sink                    req_item,
   mbp_rsp_if.source                  rsp_item
);

   localparam int STAGES   = LEVELS - 1;
   localparam int SW       = $clog2(MAX_SIDE + 1);
   localparam int RST_SIDE = (256 > MAX_SIDE) ? MAX_SIDE : 256;

   logic [SW-1:0]          side_ff, side_in;
   mbp_pkg::tok_type       tok [STAGES];
   logic                   make_st [STAGES];
   mbp_pkg::res_type       res [STAGES];
   mbp_pkg::tok_type       req_tok;
   mbp_pkg::rsp_item_type  push_item;
   logic                   push, space, busy, gate;

   // side register, clamped on write
   always_comb begin
      if (32'(csr_wdata) > 32'(MAX_SIDE)) begin
         side_in = SW'(MAX_SIDE);
      end else if (csr_wdata == '0) begin
         side_in = SW'(1);
      end else begin
         side_in = SW'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SW'(RST_SIDE);
      end else if (csr_we) begin
         side_ff <= side_in;
      end
   end

   // a cascade still in flight holds back a pixel that would start a new one
   always_comb begin
      busy = 1'b0;
      for (int l = 0; l < STAGES; l++) begin
         busy = busy | tok[l].valid;
      end
   end

   assign gate           = !busy || !make_st[0];
   assign req_item.ready = space && gate;
   assign req_tok.valid  = req_item.valid && gate;
   assign req_tok.pix    = {req_item.blue, req_item.green, req_item.red};

   // filter cells
   for (genvar l = 0; l < STAGES; l++) begin : g_cell
      mbp_pkg::tok_type up;
      logic             nxt;
      if (l == 0) begin : g_first
         assign up = req_tok;
      end else begin : g_inner
         assign up = tok[l-1];
      end
      if (l == STAGES - 1) begin : g_last
         assign nxt = 1'b0;
      end else begin : g_mid
         assign nxt = make_st[l+1];
      end
      mbp_cell #(
         .STAGE    (l),
         .MAX_SIDE (MAX_SIDE)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (space),
         .side      (side_ff),
         .up_tok    (up),
         .next_make (nxt),
         .dn_tok    (tok[l]),
         .make      (make_st[l]),
         .res       (res[l])
      );
   end

   // at most one cell finishes a texel in a cycle
   always_comb begin
      push      = 1'b0;
      push_item = '0;
      for (int l = 0; l < STAGES; l++) begin
         if (res[l].valid) begin
            push      = 1'b1;
            push_item = res[l].item;
         end
      end
   end

   mbp_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .space     (space),
      .rsp_item  (rsp_item)
   );

endmodule
